// ===== src/scfpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the size-class free pointer cache.
// No dependencies.
package scfpc_pkg;

  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned LOG_W    = 5;
  localparam int unsigned PTR_W    = 64;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_SERVED      = 3'd0,
    ST_ALLOC_BAD   = 3'd1,
    ST_ALLOC_EMPTY = 3'd2,
    ST_STORED      = 3'd3,
    ST_FREE_BAD    = 3'd4,
    ST_FREE_FULL   = 3'd5
  } status_e;

endpackage

// ===== src/scfpc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on scfpc_pkg.
interface scfpc_req_if
  import scfpc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] block_size;
  logic [PTR_W-1:0]  block_pointer;

  modport source (output valid, req_type, block_size, block_pointer, input ready);
  modport sink   (input valid, req_type, block_size, block_pointer, output ready);
endinterface

interface scfpc_rsp_if
  import scfpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [PTR_W-1:0]    pointer_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, pointer_out, status, input ready);
  modport sink   (input valid, pointer_out, status, output ready);
endinterface

// ===== src/scfpc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module scfpc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/size_class_free_pointer_cache_top.sv =====
`timescale 1ns / 1ps
// Size-class free pointer cache: one ring of returned pointers per power-of-two class.
// Depends on scfpc_pkg, scfpc_if and scfpc_ram.
//
// Requests arrive on req_i: an allocate (req_type 0) or a free (req_type 1) with a
// block size and, for a free, the block pointer. Every request gives exactly one beat
// on rsp_o with a pointer and a status code.
// One request is worked on at a time. The ring indices are read from the index memory
// in the accept cycle, and a served allocate then reads the pointer store, each memory
// having a registered read. The response sits in an output register, so the next
// request is accepted while a result still waits; if the receiver stalls, a miss or a
// free holds before its memory write, and a served allocate holds after its store read,
// until the output register is free.
// Reset clears the per-class valid bits, so every ring reads as empty with both indices
// at zero; there is no clearing pass, and requests are taken as soon as reset is released.
// Pointer store entries are only read once written.
module size_class_free_pointer_cache_top
  import scfpc_pkg::*;
#(
  parameter int unsigned CLASS_COUNT  = 32,
  parameter int unsigned RING_DEPTH   = 32,
  parameter int unsigned POINTER_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scfpc_req_if.sink   req_i,
  scfpc_rsp_if.source rsp_o
);

  localparam int unsigned CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned IDX_W   = $clog2(RING_DEPTH);
  localparam int unsigned STORE_D = CLASS_COUNT * RING_DEPTH;
  localparam int unsigned SA_W    = $clog2(STORE_D);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_FETCH  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic                    req_free_q;
  logic                    req_cls_ok_q;
  logic [CLS_W-1:0]        req_cls_q;
  logic [POINTER_BITS-1:0] req_ptr_q;
  logic [CLASS_COUNT-1:0]  idx_vld_q, idx_vld_d;
  logic                    out_valid_q, out_valid_d;
  logic [PTR_W-1:0]        out_ptr_q, out_ptr_d;
  status_e                 out_status_q, out_status_d;

  logic             in_acc;
  logic             pow2;
  logic [LOG_W-1:0] log_c;
  logic             cls_ok_c;
  logic [CLS_W-1:0] cls_c;

  logic                    idx_we;
  logic [2*IDX_W-1:0]      idx_wdata, idx_rdata;
  logic [IDX_W-1:0]        head, tail, head_nxt, tail_nxt;
  logic                    st_we, st_re;
  logic [SA_W-1:0]         st_addr;
  logic [POINTER_BITS-1:0] st_rdata;
  logic                    out_free;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  always_comb begin
    log_c = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (req_i.block_size[i]) begin
        log_c = log_c | LOG_W'(i);
      end
    end
    pow2     = (req_i.block_size != '0) &&
               ((req_i.block_size & (req_i.block_size - SIZE_W'(1))) == '0);
    cls_ok_c = pow2 && (32'(log_c) < 32'(CLASS_COUNT));
    cls_c    = CLS_W'(log_c);
  end

  scfpc_ram #(
    .WIDTH(2 * IDX_W),
    .DEPTH(CLASS_COUNT)
  ) u_idx_ram (
    .clk_i  (clk_i),
    .we_i   (idx_we),
    .waddr_i(req_cls_q),
    .wdata_i(idx_wdata),
    .re_i   (in_acc),
    .raddr_i(cls_c),
    .rdata_o(idx_rdata)
  );

  scfpc_ram #(
    .WIDTH(POINTER_BITS),
    .DEPTH(STORE_D)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_addr),
    .wdata_i(req_ptr_q),
    .re_i   (st_re),
    .raddr_i(st_addr),
    .rdata_o(st_rdata)
  );

  always_comb begin
    head     = idx_vld_q[req_cls_q] ? idx_rdata[2*IDX_W-1:IDX_W] : '0;
    tail     = idx_vld_q[req_cls_q] ? idx_rdata[IDX_W-1:0] : '0;
    head_nxt = (head == IDX_W'(RING_DEPTH - 1)) ? '0 : head + IDX_W'(1);
    tail_nxt = (tail == IDX_W'(RING_DEPTH - 1)) ? '0 : tail + IDX_W'(1);
    st_addr  = SA_W'(req_cls_q) * SA_W'(RING_DEPTH) + SA_W'(req_free_q ? tail : head);
    out_free = !out_valid_q || rsp_o.ready;

    state_d      = state_q;
    idx_vld_d    = idx_vld_q;
    idx_we       = 1'b0;
    idx_wdata    = {head, tail};
    st_we        = 1'b0;
    st_re        = 1'b0;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_ptr_d    = out_ptr_q;
    out_status_d = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!req_free_q && req_cls_ok_q && (head != tail)) begin
          st_re     = 1'b1;
          idx_we    = 1'b1;
          idx_wdata = {head_nxt, tail};
          idx_vld_d[req_cls_q] = 1'b1;
          state_d   = S_FETCH;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_ptr_d   = '0;
          state_d     = S_IDLE;
          if (!req_cls_ok_q) begin
            out_status_d = req_free_q ? ST_FREE_BAD : ST_ALLOC_BAD;
          end else if (!req_free_q) begin
            out_status_d = ST_ALLOC_EMPTY;
          end else if (tail_nxt == head) begin
            out_status_d = ST_FREE_FULL;
          end else begin
            out_status_d = ST_STORED;
            st_we        = 1'b1;
            idx_we       = 1'b1;
            idx_wdata    = {head, tail_nxt};
            idx_vld_d[req_cls_q] = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_ptr_d    = PTR_W'(st_rdata);
          out_status_d = ST_SERVED;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_vld_q   <= idx_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_free_q   <= req_i.req_type;
      req_cls_ok_q <= cls_ok_c;
      req_cls_q    <= cls_c;
      req_ptr_q    <= req_i.block_pointer[POINTER_BITS-1:0];
    end
    out_ptr_q    <= out_ptr_d;
    out_status_q <= out_status_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pointer_out = out_ptr_q;
  assign rsp_o.status      = out_status_q;

endmodule

// ===== src/scfpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the size-class free pointer cache, bound to the top level.
// Depends on scfpc_pkg and size_class_free_pointer_cache_top.
module scfpc_checker
  import scfpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [PTR_W-1:0]    pointer_out_i,
  input logic [STATUS_W-1:0] status_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(pointer_out_i) && $stable(status_i))
    else $error("Stalled response beat changed.");

  a_ptr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_SERVED) |-> pointer_out_i == '0)
    else $error("Pointer is not zero on a response that was not served.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("Request taken while another is still in progress.");

  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !(rsp_valid_i && !rsp_ready_i) |=> !rsp_valid_i)
    else $error("Response beat appeared in the cycle after acceptance.");

endmodule

bind size_class_free_pointer_cache_top scfpc_checker u_scfpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .pointer_out_i(rsp_o.pointer_out),
  .status_i     (rsp_o.status)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the size-class free pointer cache: directed and random
// allocate and free requests, with every response beat checked against a built-in predictor.
// Depends on scfpc_pkg, scfpc_if and size_class_free_pointer_cache_top.
module testbench;
  import scfpc_pkg::*;

  localparam int unsigned CLASS_COUNT    = 32;
  localparam int unsigned RING_DEPTH     = 32;
  localparam int unsigned POINTER_BITS   = 64;
  localparam int unsigned WATCHDOG_LIMIT = 200;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PRINT_LIMIT    = 50;
  localparam logic [PTR_W-1:0] PTR_MASK  = {PTR_W{1'b1}} >> (PTR_W - POINTER_BITS);

  typedef struct packed {
    logic [PTR_W-1:0] pointer;
    status_e          status;
  } rsp_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  scfpc_req_if req_ch ();
  scfpc_rsp_if rsp_ch ();

  size_class_free_pointer_cache_top #(
    .CLASS_COUNT (CLASS_COUNT),
    .RING_DEPTH  (RING_DEPTH),
    .POINTER_BITS(POINTER_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  int unsigned      rd_idx [CLASS_COUNT] = '{default: 0};
  int unsigned      wr_idx [CLASS_COUNT] = '{default: 0};
  logic [PTR_W-1:0] ring_mem [CLASS_COUNT][RING_DEPTH];
  rsp_beat_t        expected_rsp_q [$];
  int unsigned      error_count = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      stall_left = 0;
  bit               src_idle_en = 1'b0;
  bit               snk_idle_en = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int class_of_size(input logic [SIZE_W-1:0] sz);
    int cls;
    cls = -1;
    if (sz != '0 && (sz & (sz - SIZE_W'(1))) == '0) begin
      for (int k = 0; k < SIZE_W; k++) begin
        if (sz[k]) cls = k;
      end
      if (cls >= int'(CLASS_COUNT)) cls = -1;
    end
    return cls;
  endfunction

  function automatic rsp_beat_t serve_request(input logic is_free,
                                              input logic [SIZE_W-1:0] sz,
                                              input logic [PTR_W-1:0] ptr);
    rsp_beat_t beat;
    int cls;
    int unsigned nxt;
    beat.pointer = '0;
    cls = class_of_size(sz);
    if (!is_free) begin
      if (cls < 0) begin
        beat.status = ST_ALLOC_BAD;
      end else if (rd_idx[cls] == wr_idx[cls]) begin
        beat.status = ST_ALLOC_EMPTY;
      end else begin
        beat.pointer = ring_mem[cls][rd_idx[cls]];
        rd_idx[cls] = (rd_idx[cls] + 1) % RING_DEPTH;
        beat.status = ST_SERVED;
      end
    end else begin
      if (cls < 0) begin
        beat.status = ST_FREE_BAD;
      end else begin
        nxt = (wr_idx[cls] + 1) % RING_DEPTH;
        if (nxt == rd_idx[cls]) begin
          beat.status = ST_FREE_FULL;
        end else begin
          ring_mem[cls][wr_idx[cls]] = ptr & PTR_MASK;
          wr_idx[cls] = nxt;
          beat.status = ST_STORED;
        end
      end
    end
    return beat;
  endfunction

  function automatic logic [PTR_W-1:0] rand_ptr();
    return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(input string field, input logic [PTR_W-1:0] want,
                                 input logic [PTR_W-1:0] got);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, field, want, got);
    error_count++;
  endtask

  task automatic send_request(input logic is_free, input logic [SIZE_W-1:0] sz,
                              input logic [PTR_W-1:0] ptr);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= is_free;
    req_ch.block_size    <= sz;
    req_ch.block_pointer <= ptr;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    expected_rsp_q.push_back(serve_request(is_free, sz, ptr));
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_beat_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("beat with nothing expected", '0, rsp_ch.pointer_out);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_ch.pointer_out !== want.pointer)
          report_mismatch("pointer_out", want.pointer, rsp_ch.pointer_out);
        if (rsp_ch.status !== want.status)
          report_mismatch("status", PTR_W'(want.status), PTR_W'(rsp_ch.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_bad_sizes();
    send_request(1'b0, 32'h0000_0000, rand_ptr());
    send_request(1'b0, 32'h0000_0003, rand_ptr());
    send_request(1'b0, 32'hFFFF_FFFF, rand_ptr());
    send_request(1'b1, 32'h0000_0000, rand_ptr());
    send_request(1'b1, 32'hFFFF_FFFF, {PTR_W{1'b1}});
    send_request(1'b1, 32'h0000_0006, rand_ptr());
    send_request(1'b1, 32'h8000_0001, rand_ptr());
  endtask

  task automatic test_empty_rings();
    send_request(1'b0, 32'h0000_0001, rand_ptr());
    send_request(1'b0, 32'h8000_0000, rand_ptr());
    send_request(1'b0, 32'h0001_0000, rand_ptr());
  endtask

  task automatic test_store_and_serve();
    send_request(1'b1, 32'h0000_0001, {PTR_W{1'b1}});
    send_request(1'b1, 32'h8000_0000, '0);
    send_request(1'b1, 32'h0000_0001, 64'h0123_4567_89AB_CDEF);
    send_request(1'b0, 32'h8000_0000, rand_ptr());
    send_request(1'b0, 32'h0000_0001, rand_ptr());
    send_request(1'b0, 32'h0000_0001, rand_ptr());
    send_request(1'b0, 32'h0000_0001, rand_ptr());
    send_request(1'b1, 32'h0000_0004, 64'h5555_AAAA_5555_AAAA);
    send_request(1'b0, 32'h0000_0004, rand_ptr());
  endtask

  // Each round fills one ring past full, then drains it past empty.
  task automatic test_ring_fill(input int unsigned rounds);
    int unsigned cls;
    logic [SIZE_W-1:0] sz;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    for (int unsigned r = 0; r < rounds; r++) begin
      if (r == 0) cls = 0;
      else if (r == 1) cls = CLASS_COUNT - 1;
      else cls = $urandom_range(0, CLASS_COUNT - 1);
      sz = SIZE_W'(1) << cls;
      repeat (RING_DEPTH + 2) send_request(1'b1, sz, rand_ptr());
      repeat (RING_DEPTH + 2) send_request(1'b0, sz, rand_ptr());
    end
  endtask

  // Long phases of mostly frees then mostly allocates on two busy classes, with noise.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned hot [2];
    bit filling;
    int unsigned roll;
    logic [SIZE_W-1:0] sz;
    filling = 1'b1;
    hot[0] = $urandom_range(0, CLASS_COUNT - 1);
    hot[1] = $urandom_range(0, CLASS_COUNT - 1);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (i % 120 == 0 && i != 0) begin
        filling = !filling;
        if (filling) begin
          hot[0] = $urandom_range(0, CLASS_COUNT - 1);
          hot[1] = $urandom_range(0, CLASS_COUNT - 1);
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) sz = $urandom();
      else if (roll < 8) sz = '0;
      else if (roll < 12)
        sz = (SIZE_W'(1) << $urandom_range(0, SIZE_W - 1)) |
             (SIZE_W'(1) << $urandom_range(0, SIZE_W - 1));
      else if (roll < 22) sz = SIZE_W'(1) << $urandom_range(0, CLASS_COUNT - 1);
      else sz = SIZE_W'(1) << hot[$urandom_range(0, 1)];
      send_request($urandom_range(0, 99) < (filling ? 85 : 15), sz, rand_ptr());
    end
  endtask

  task automatic test_streaming(input int unsigned n_items);
    logic [SIZE_W-1:0] sz;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) == 0) sz = $urandom();
      else sz = SIZE_W'(1) << $urandom_range(0, 3);
      send_request(1'($urandom_range(0, 1)), sz, rand_ptr());
    end
  endtask

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = 1'b0;
    req_ch.block_size    = '0;
    req_ch.block_pointer = '0;
    rsp_ch.ready         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_bad_sizes();
    test_empty_rings();
    test_store_and_serve();
    test_ring_fill(5);
    test_random_traffic(1040);
    test_streaming(160);
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
